[rtl/core/column_min_depth_kalman_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check wrappers shared by the column minimum depth filter RTL.
// ----------------------------------------------------------------------------
`ifndef COLUMN_MIN_DEPTH_KALMAN_MACROS_SVH
`define COLUMN_MIN_DEPTH_KALMAN_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define CMDK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmdk: same-cycle check failed");
// next-cycle implication
`define CMDK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmdk: next-cycle check failed");
`else
`define CMDK_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CMDK_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/cmdk_pkg.sv]
// ----------------------------------------------------------------------------
// cmdk_pkg
// Shared widths, reset values and codes of the column minimum depth filter.
// ----------------------------------------------------------------------------
package cmdk_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    localparam int DEPTH_W = 16;   // millimetre pixels and limits
    localparam int VAL_W   = 32;   // estimate, covariance, noise terms
    localparam int DATA_W  = 32;   // APB data
    localparam int ADDR_W  = 5;    // APB byte address

    localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST = 16'd1000;
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 16'd3500;
    localparam logic [DEPTH_W-1:0] SEED_THR_RST  = 16'd50;
    localparam logic [VAL_W-1:0]   PROC_NOISE_RST = 32'd98304;
    localparam logic [VAL_W-1:0]   MEAS_NOISE_RST = 32'd524288000;

    typedef enum logic [1:0] {
        OUT_UPDATED  = 2'd0,
        OUT_SEEDED   = 2'd1,
        OUT_REJECTED = 2'd2
    } outcome_t;

    // register index, byte address = 4 * index
    typedef enum logic [2:0] {
        REG_MIN_DEPTH     = 3'd0,
        REG_MAX_DEPTH     = 3'd1,
        REG_SEED_THR      = 3'd2,
        REG_PROCESS_NOISE = 3'd3,
        REG_MEASURE_NOISE = 3'd4
    } reg_idx_t;

endpackage

[rtl/core/column_min_depth_kalman.sv]
// ----------------------------------------------------------------------------
// column_min_depth_kalman
// Column minimum depth tracker with a fixed-point scalar Kalman filter.
// ----------------------------------------------------------------------------
// Pixels of one image column arrive one request per cycle; the smallest
// nonzero pixel is tracked as they pass. The request flagged last_pixel
// closes the column: the minimum is judged against the min/max band, and
// if it passes, the estimate is either seeded (estimate below the seed
// threshold) or put through predict, gain and correct. One result request
// leaves per column. After a last pixel the input stalls: on a rejected
// or seeded column through the judge and finish states, and on a filter
// update also through the prep, divide and two multiply states. The
// restoring divider produces one gain bit per cycle and is followed by
// two passes through the single shared multiplier (gain times innovation,
// then (1 - gain) times predicted covariance). A pending
// result waits in the output register and does not block pixel requests;
// only the end of the next column waits for it to be taken. Estimate and
// covariance are unsigned with FRACTION_BITS fraction bits in 32 bits; the
// gain carries FRACTION_BITS + 1 bits so that a gain of exactly 1.0 fits.
// Registers on APB at 4 * index: min_depth, max_depth, seed_threshold,
// process_noise, measure_noise; write them only while the block is idle.
// ----------------------------------------------------------------------------
`include "column_min_depth_kalman_macros.svh"

module column_min_depth_kalman #(
    parameter int FRACTION_BITS = cmdk_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cmdk_pkg::ADDR_W-1:0]   paddr,
    input  logic [cmdk_pkg::DATA_W-1:0]   pwdata,
    output logic [cmdk_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // pixel requests
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cmdk_pkg::DEPTH_W-1:0]  pixel_depth,
    input  logic                          last_pixel,
    // result requests
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cmdk_pkg::DEPTH_W-1:0]  filtered_depth,
    output logic [cmdk_pkg::DEPTH_W-1:0]  measured_min,
    output logic [1:0]                    outcome
);

    localparam int DEPTH_W = cmdk_pkg::DEPTH_W;
    localparam int VAL_W   = cmdk_pkg::VAL_W;
    localparam int DATA_W  = cmdk_pkg::DATA_W;
    localparam int ADDR_W  = cmdk_pkg::ADDR_W;
    localparam int GAIN_W  = FRACTION_BITS + 1;
    localparam int PROD_W  = GAIN_W + VAL_W;
    localparam int WIDE_W  = DEPTH_W + FRACTION_BITS + VAL_W;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRACTION_BITS;
    localparam logic [VAL_W-1:0]  COV_RST  = VAL_W'(1) << FRACTION_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_JUDGE,
        ST_PREP,
        ST_DIV,
        ST_MUL_CORR,
        ST_MUL_COV,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [DEPTH_W-1:0] min_depth_reg;
    logic [DEPTH_W-1:0] max_depth_reg;
    logic [DEPTH_W-1:0] seed_thr_reg;
    logic [VAL_W-1:0]   q_reg;
    logic [VAL_W-1:0]   r_reg;

    // column and filter state
    logic [DEPTH_W-1:0] running_min_reg;
    logic               any_valid_reg;
    logic [VAL_W-1:0]   estimate_reg;
    logic [VAL_W-1:0]   covariance_reg;

    // per-column working registers
    logic [DEPTH_W-1:0]  meas_reg;
    logic                col_valid_reg;
    cmdk_pkg::outcome_t  outcome_reg;
    logic [VAL_W-1:0]    z_reg;
    logic [VAL_W-1:0]    p_reg;
    logic [VAL_W-1:0]    diff_reg;
    logic                up_reg;
    logic [PROD_W-1:0]   prod_reg;

    // output register
    logic                out_valid_reg;
    logic [DEPTH_W-1:0]  out_depth_reg;
    logic [DEPTH_W-1:0]  out_min_reg;
    cmdk_pkg::outcome_t  out_outcome_reg;

    logic               in_fire;
    logic               out_fire;
    logic               cfg_wr;
    logic               fin_go;
    logic               px_valid;
    logic               px_lower;
    logic [DEPTH_W-1:0] min_next;
    logic               any_next;
    logic               in_band;
    logic [WIDE_W-1:0]  est_wide;
    logic [WIDE_W-1:0]  seed_wide;
    logic [WIDE_W-1:0]  meas_wide;
    logic               seed_now;
    logic [VAL_W-1:0]   z_val;
    logic [VAL_W:0]     p_sum;
    logic [VAL_W-1:0]   p_sat;
    logic [VAL_W:0]     den_sum;
    logic               z_up;
    logic [VAL_W-1:0]   diff_val;
    logic [GAIN_W-1:0]  mul_a;
    logic [VAL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [VAL_W-1:0]   corr;
    logic [VAL_W-1:0]   est_corr;
    logic [VAL_W-1:0]   est_shift;

    logic               div_start;
    logic [GAIN_W-1:0]  div_quo;
    logic               div_done;

    // ---- handshakes ----
    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid & in_ready;
    assign out_fire = out_valid_reg & out_ready;
    assign fin_go   = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    // ---- running minimum, this pixel included ----
    assign px_valid = (pixel_depth != '0);
    assign px_lower = !any_valid_reg || (pixel_depth < running_min_reg);
    assign min_next = (px_valid && px_lower) ? pixel_depth : running_min_reg;
    assign any_next = any_valid_reg | px_valid;

    // ---- judge: band check, seed test, measurement in fixed point ----
    assign in_band   = (meas_reg >= min_depth_reg) && (meas_reg <= max_depth_reg);
    assign est_wide  = WIDE_W'(estimate_reg);
    assign seed_wide = WIDE_W'(seed_thr_reg) << FRACTION_BITS;
    assign meas_wide = WIDE_W'(meas_reg) << FRACTION_BITS;
    assign seed_now  = (est_wide < seed_wide);
    assign z_val     = (|meas_wide[WIDE_W-1:VAL_W]) ? '1 : meas_wide[VAL_W-1:0];

    // predicted covariance, saturating
    assign p_sum = {1'b0, covariance_reg} + {1'b0, q_reg};
    assign p_sat = p_sum[VAL_W] ? '1 : p_sum[VAL_W-1:0];

    // gain denominator kept at full width, no wrap
    assign den_sum  = {1'b0, p_reg} + {1'b0, r_reg};
    assign z_up     = (z_reg > estimate_reg);
    assign diff_val = z_up ? (z_reg - estimate_reg) : (estimate_reg - z_reg);

    // ---- shared multiplier ----
    always_comb
    begin
        if (state_reg == ST_MUL_CORR)
        begin
            mul_a = div_quo;
            mul_b = diff_reg;
        end
        else
        begin
            mul_a = GAIN_ONE - div_quo;
            mul_b = p_reg;
        end
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // correction never exceeds the innovation, so no wrap either way
    assign corr      = prod_reg[FRACTION_BITS +: VAL_W];
    assign est_corr  = up_reg ? (estimate_reg + corr) : (estimate_reg - corr);
    assign est_shift = estimate_reg >> FRACTION_BITS;

    assign div_start = (state_reg == ST_PREP);

    cmdk_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (p_reg),
        .divisor  (den_sum),
        .quotient (div_quo),
        .done     (div_done)
    );

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && last_pixel)
                begin
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE:
            begin
                if (!col_valid_reg || !in_band || seed_now)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:     state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL_CORR;
                end
            end
            ST_MUL_CORR: state_next = ST_MUL_COV;
            ST_MUL_COV:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // ---- state, configuration, filter state and output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            min_depth_reg   <= cmdk_pkg::MIN_DEPTH_RST;
            max_depth_reg   <= cmdk_pkg::MAX_DEPTH_RST;
            seed_thr_reg    <= cmdk_pkg::SEED_THR_RST;
            q_reg           <= cmdk_pkg::PROC_NOISE_RST;
            r_reg           <= cmdk_pkg::MEAS_NOISE_RST;
            running_min_reg <= '1;
            any_valid_reg   <= 1'b0;
            estimate_reg    <= '0;
            covariance_reg  <= COV_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr)
            begin
                unique case (paddr[ADDR_W-1:2])
                    cmdk_pkg::REG_MIN_DEPTH:     min_depth_reg <= pwdata[DEPTH_W-1:0];
                    cmdk_pkg::REG_MAX_DEPTH:     max_depth_reg <= pwdata[DEPTH_W-1:0];
                    cmdk_pkg::REG_SEED_THR:      seed_thr_reg  <= pwdata[DEPTH_W-1:0];
                    cmdk_pkg::REG_PROCESS_NOISE: q_reg         <= pwdata[VAL_W-1:0];
                    cmdk_pkg::REG_MEASURE_NOISE: r_reg         <= pwdata[VAL_W-1:0];
                    default:                     ;
                endcase
            end

            if (in_fire)
            begin
                if (last_pixel)
                begin
                    running_min_reg <= '1;
                    any_valid_reg   <= 1'b0;
                end
                else
                begin
                    running_min_reg <= min_next;
                    any_valid_reg   <= any_next;
                end
            end

            if (state_reg == ST_JUDGE && col_valid_reg && in_band && seed_now)
            begin
                estimate_reg <= z_val;
            end

            if (state_reg == ST_MUL_COV)
            begin
                estimate_reg <= est_corr;
            end

            // product holds while waiting, so a repeated write is harmless
            if (state_reg == ST_FIN && outcome_reg == cmdk_pkg::OUT_UPDATED)
            begin
                covariance_reg <= prod_reg[FRACTION_BITS +: VAL_W];
            end

            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire && last_pixel)
        begin
            meas_reg      <= any_next ? min_next : '0;
            col_valid_reg <= any_next;
        end

        if (state_reg == ST_JUDGE)
        begin
            z_reg <= z_val;
            p_reg <= p_sat;
            if (!col_valid_reg || !in_band)
            begin
                outcome_reg <= cmdk_pkg::OUT_REJECTED;
            end
            else if (seed_now)
            begin
                outcome_reg <= cmdk_pkg::OUT_SEEDED;
            end
            else
            begin
                outcome_reg <= cmdk_pkg::OUT_UPDATED;
            end
        end

        if (state_reg == ST_PREP)
        begin
            diff_reg <= diff_val;
            up_reg   <= z_up;
        end

        if (state_reg == ST_MUL_CORR || state_reg == ST_MUL_COV)
        begin
            prod_reg <= mul_p;
        end

        if (fin_go)
        begin
            out_depth_reg   <= est_shift[DEPTH_W-1:0];
            out_min_reg     <= meas_reg;
            out_outcome_reg <= outcome_reg;
        end
    end

    // ---- APB read ----
    always_comb
    begin
        unique case (paddr[ADDR_W-1:2])
            cmdk_pkg::REG_MIN_DEPTH:     prdata = DATA_W'(min_depth_reg);
            cmdk_pkg::REG_MAX_DEPTH:     prdata = DATA_W'(max_depth_reg);
            cmdk_pkg::REG_SEED_THR:      prdata = DATA_W'(seed_thr_reg);
            cmdk_pkg::REG_PROCESS_NOISE: prdata = DATA_W'(q_reg);
            cmdk_pkg::REG_MEASURE_NOISE: prdata = DATA_W'(r_reg);
            default:                     prdata = '0;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign filtered_depth = out_depth_reg;
    assign measured_min   = out_min_reg;
    assign outcome        = out_outcome_reg;

    // ---- checks ----
    `CMDK_ASSERT_NXT(a_last_stalls, clk, rst_n, in_fire && last_pixel, !in_ready)
    `CMDK_ASSERT_IMP(a_done_in_div, clk, rst_n, div_done, state_reg == ST_DIV)
    `CMDK_ASSERT_IMP(a_gain_le_one, clk, rst_n, state_reg == ST_MUL_CORR, div_quo <= GAIN_ONE)
    `CMDK_ASSERT_IMP(a_cov_shrinks, clk, rst_n, state_reg == ST_FIN && outcome_reg == cmdk_pkg::OUT_UPDATED, prod_reg[FRACTION_BITS +: VAL_W] <= p_reg)

endmodule

[rtl/core/cmdk_div.sv]
// ----------------------------------------------------------------------------
// cmdk_div
// Restoring divider for the Kalman gain, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cmdk_div #(
    parameter int FRACTION_BITS = cmdk_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cmdk_pkg::VAL_W-1:0]    dividend,
    input  logic [cmdk_pkg::VAL_W:0]      divisor,
    output logic [FRACTION_BITS:0]        quotient,
    output logic                          done
);

    localparam int QUO_W = FRACTION_BITS + 1;
    localparam int DEN_W = cmdk_pkg::VAL_W + 1;
    localparam int REM_W = cmdk_pkg::VAL_W + 2;
    localparam int CNT_W = $clog2(FRACTION_BITS + 1);

    logic [REM_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic             q_bit;
    logic [REM_W-1:0] rem_sub;

    // dividend <= divisor, so the quotient never exceeds 2^F; zero divisor gives 0
    assign q_bit   = (rem_reg >= REM_W'(den_reg)) && (den_reg != '0);
    assign rem_sub = q_bit ? (rem_reg - REM_W'(den_reg)) : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(FRACTION_BITS);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= REM_W'(dividend);
            den_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= {rem_sub[REM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], q_bit};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Column minimum depth filter testbench
// Streams depth pixel columns through the block and checks every column
// result against a cycle-free prediction of the column minimum, the band
// test and the fixed-point Kalman seed/update.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH_W = cmdk_pkg::DEPTH_W;
    localparam int VAL_W   = cmdk_pkg::VAL_W;
    localparam int DATA_W  = cmdk_pkg::DATA_W;
    localparam int ADDR_W  = cmdk_pkg::ADDR_W;

    localparam int FB = cmdk_pkg::FRACTION_BITS_DEF;
    // A filter update holds the input the longest; leave some margin.
    localparam int SETTLE_CYCLES = FB + 20;
    // Worst case per pixel: long sender gap, full update, long receiver stall.
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               last;
        logic               hold;   // wait for all results before sending
    } pixel_req_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [DEPTH_W-1:0] col_min;
        cmdk_pkg::outcome_t verdict;
    } column_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [DEPTH_W-1:0] pixel_depth = '0;
    logic               last_pixel = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [DEPTH_W-1:0] filtered_depth;
    logic [DEPTH_W-1:0] measured_min;
    logic [1:0]         outcome;

    pixel_req_t     pixel_queue[$];
    column_result_t expected_columns[$];
    int             error_count = 0;
    int             cycle_count = 0;
    int             gap_left = 0;
    int             stall_left = 0;
    logic           steady = 1'b0;   // no idling on either side

    // Shadow of the configuration registers
    logic [DEPTH_W-1:0] cfg_min = cmdk_pkg::MIN_DEPTH_RST;
    logic [DEPTH_W-1:0] cfg_max = cmdk_pkg::MAX_DEPTH_RST;
    logic [DEPTH_W-1:0] cfg_seed = cmdk_pkg::SEED_THR_RST;
    logic [VAL_W-1:0]   cfg_q = cmdk_pkg::PROC_NOISE_RST;
    logic [VAL_W-1:0]   cfg_r = cmdk_pkg::MEAS_NOISE_RST;

    // Predicted filter state
    logic [DEPTH_W-1:0] col_min = '1;
    logic               col_seen = 1'b0;
    logic [VAL_W-1:0]   est = '0;
    logic [VAL_W-1:0]   cov = VAL_W'(64'd1 << FB);

    column_min_depth_kalman DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pixel_depth    (pixel_depth),
        .last_pixel     (last_pixel),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_depth (filtered_depth),
        .measured_min   (measured_min),
        .outcome        (outcome)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] sat32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // Fold one accepted pixel into the column; on the last pixel judge the
    // minimum, run seed or predict/gain/correct, and queue the result.
    function automatic void predict_pixel(logic [DEPTH_W-1:0] px, logic last);
        column_result_t res;
        logic [DEPTH_W-1:0] meas;
        logic [63:0] z, p, den, gain, e, diff, corr;
        if (px != '0)
        begin
            if (!col_seen || px < col_min)
                col_min = px;
            col_seen = 1'b1;
        end
        if (!last)
            return;
        meas = col_seen ? col_min : '0;
        if (!col_seen || meas < cfg_min || meas > cfg_max)
            res.verdict = cmdk_pkg::OUT_REJECTED;
        else
        begin
            z = 64'(sat32(64'(meas) << FB));
            if (64'(est) < (64'(cfg_seed) << FB))
            begin
                est = z[31:0];
                res.verdict = cmdk_pkg::OUT_SEEDED;
            end
            else
            begin
                p = 64'(sat32(64'(cov) + 64'(cfg_q)));
                den = p + 64'(cfg_r);   // 33 bits, no wrap
                gain = (den != 0) ? (p << FB) / den : 64'd0;
                e = 64'(est);
                diff = (z > e) ? z - e : e - z;
                corr = (gain * diff) >> FB;
                e = (z > e) ? e + corr : e - corr;
                est = sat32(e);
                cov = sat32((((64'd1 << FB) - gain) * p) >> FB);
                res.verdict = cmdk_pkg::OUT_UPDATED;
            end
        end
        res.depth = DEPTH_W'(est >> FB);
        res.col_min = meas;
        expected_columns.insert(expected_columns.size(), res);
        col_min = '1;
        col_seen = 1'b0;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic void push_pixel(logic [DEPTH_W-1:0] d, logic l, logic h = 1'b0);
        pixel_req_t req;
        req.depth = d;
        req.last = l;
        req.hold = h;
        pixel_queue.insert(pixel_queue.size(), req);
    endfunction

    // Pixel values: zeros, full-range noise, band edges, and mostly in-band.
    function automatic logic [DEPTH_W-1:0] draw_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return '0;
        if (r < 25)
            return DEPTH_W'($urandom);
        if (r < 32)
        begin
            case ($urandom_range(0, 5))
                0: return 16'd1;
                1: return 16'hFFFF;
                2: return cfg_min;
                3: return cfg_max;
                4: return cfg_min - 16'd1;
                default: return cfg_max + 16'd1;
            endcase
        end
        if (cfg_min <= cfg_max)
            return DEPTH_W'($urandom_range(cfg_max, cfg_min));
        return DEPTH_W'($urandom);
    endfunction

    // Whole columns only, so that every phase ends on a column boundary.
    function automatic void fill_columns(int count);
        int n;
        int len;
        int r;
        logic blank;
        n = 0;
        while (n < count)
        begin
            r = $urandom_range(0, 99);
            len = (r < 70) ? $urandom_range(1, 6) :
                  (r < 95) ? $urandom_range(7, 20) : $urandom_range(21, 60);
            blank = ($urandom_range(0, 19) == 0);
            for (int i = 0; i < len; i++)
                push_pixel(blank ? 16'd0 : draw_pixel(), i == len - 1,
                           i == 0 && ($urandom_range(0, 24) == 0 || n == 0));
            n += len;
        end
    endfunction

    // APB write: setup cycle, then access cycle; the register takes the
    // value at the edge that closes the access.
    task automatic write_reg(cmdk_pkg::reg_idx_t idx, logic [DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            cmdk_pkg::REG_MIN_DEPTH:     cfg_min = value[DEPTH_W-1:0];
            cmdk_pkg::REG_MAX_DEPTH:     cfg_max = value[DEPTH_W-1:0];
            cmdk_pkg::REG_SEED_THR:      cfg_seed = value[DEPTH_W-1:0];
            cmdk_pkg::REG_PROCESS_NOISE: cfg_q = value[VAL_W-1:0];
            cmdk_pkg::REG_MEASURE_NOISE: cfg_r = value[VAL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [DEPTH_W-1:0] lo, logic [DEPTH_W-1:0] hi,
                             logic [DEPTH_W-1:0] seed, logic [VAL_W-1:0] q,
                             logic [VAL_W-1:0] r);
        write_reg(cmdk_pkg::REG_MIN_DEPTH, DATA_W'(lo));
        write_reg(cmdk_pkg::REG_MAX_DEPTH, DATA_W'(hi));
        write_reg(cmdk_pkg::REG_SEED_THR, DATA_W'(seed));
        write_reg(cmdk_pkg::REG_PROCESS_NOISE, q);
        write_reg(cmdk_pkg::REG_MEASURE_NOISE, r);
    endtask

    // Block idle: all pixels taken, all results back, divider long finished.
    task automatic settle();
        while (pixel_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_columns.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Pixel driver: predicts each accepted request, then offers the next
    // one unless a gap is running or the head asks for a full drain.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        pixel_req_t next_req;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                predict_pixel(pixel_depth, last_pixel);
            if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pixel_queue.size() != 0 &&
                     !(pixel_queue[0].hold && expected_columns.size() != 0))
            begin
                next_req = pixel_queue.pop_front();
                pixel_depth <= next_req.depth;
                last_pixel <= next_req.last;
                in_valid <= 1'b1;
                gap_left <= draw_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, and each taken result request
    // is checked field by field against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        column_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_columns.size() == 0)
                begin
                    $error("unexpected result: filtered_depth %0d measured_min %0d outcome %0d",
                           filtered_depth, measured_min, outcome);
                    error_count++;
                end
                else
                begin
                    want = expected_columns.pop_front();
                    if (filtered_depth !== want.depth)
                    begin
                        $error("filtered_depth: expected %0d, got %0d",
                               want.depth, filtered_depth);
                        error_count++;
                    end
                    if (measured_min !== want.col_min)
                    begin
                        $error("measured_min: expected %0d, got %0d",
                               want.col_min, measured_min);
                        error_count++;
                    end
                    if (outcome !== want.verdict)
                    begin
                        $error("outcome: expected %0d, got %0d", want.verdict, outcome);
                        error_count++;
                    end
                end
            end
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_valid && out_ready)
                    stall_left <= draw_gap();
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed columns under reset and degenerate settings,
    // then random phases, each under its own register setting.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset band 1000..3500, estimate starts at zero so first good
        // column seeds.
        push_pixel(16'd0, 1'b1);                     // no valid pixel
        push_pixel(16'd0, 1'b0);
        push_pixel(16'd2000, 1'b0);
        push_pixel(16'd0, 1'b0);
        push_pixel(16'd1500, 1'b1);                  // seeds from 1500
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'd3000, 1'b1);                  // first update
        push_pixel(16'd999, 1'b1);                   // just below band
        push_pixel(16'd3501, 1'b1);                  // just above band
        push_pixel(16'd1000, 1'b1, 1'b1);            // lower edge, after drain
        push_pixel(16'd3500, 1'b1);                  // upper edge
        push_pixel(16'd1, 1'b0);
        push_pixel(16'd0, 1'b0);
        push_pixel(16'd1, 1'b1);                     // tiny minimum, rejected
        settle();

        // Zero noise: R = 0 gives a gain of exactly 1.0 and zero covariance,
        // after which P' + R = 0 and the gain drops to zero.
        write_all(16'd0, 16'hFFFF, 16'd0, 32'd0, 32'd0);
        push_pixel(16'd5000, 1'b1);
        push_pixel(16'd20, 1'b1);
        push_pixel(16'hFFFF, 1'b1);
        push_pixel(16'd0, 1'b0);
        push_pixel(16'd0, 1'b1);
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_all(cmdk_pkg::MIN_DEPTH_RST, cmdk_pkg::MAX_DEPTH_RST,
                             cmdk_pkg::SEED_THR_RST, cmdk_pkg::PROC_NOISE_RST,
                             cmdk_pkg::MEAS_NOISE_RST);
                // Saturating P', seed threshold so high it nearly always seeds
                1: write_all(16'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2: write_all(DEPTH_W'($urandom_range(0, 2000)),
                             DEPTH_W'($urandom_range(2500, 6000)),
                             DEPTH_W'($urandom_range(0, 100)),
                             $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 24));
                3: write_all(DEPTH_W'($urandom_range(0, 32767)),
                             DEPTH_W'($urandom_range(32768, 65535)),
                             DEPTH_W'($urandom), $urandom, $urandom);
                // Empty band: min above max, everything rejected
                4: write_all(16'd3000, 16'd100, DEPTH_W'($urandom), $urandom, $urandom);
                default: write_all(DEPTH_W'($urandom_range(1, 500)),
                                   DEPTH_W'($urandom_range(10000, 65535)),
                                   16'd0, 32'd0, $urandom_range(0, 255));
            endcase
            steady = (ph == 2);
            fill_columns((ph == 4) ? 40 : 125);
            settle();
        end

        if (error_count == 0 && expected_columns.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
